/* hdl/salc_pkg.sv */
// Package with shared types and constants of the set-associative LRU cache statistics block.
package salc_pkg;

  // Fixed field widths of the channels.
  localparam int ADDR_W     = 64;
  localparam int CNT_W      = 48;
  localparam int NOW_W      = 30;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam int SET_CFG_W  = 4;
  localparam int BLK_CFG_W  = 5;
  localparam int WAY_CFG_W  = 4;

  // Saturation limits and block size limit.
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam logic [NOW_W-1:0] NOW_MAX = {NOW_W{1'b1}};
  localparam logic [BLK_CFG_W-1:0] BLOCK_BITS_MAX = 5'd16;

  // Access kinds.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_STORE = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_USED  = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [SET_CFG_W-1:0] SET_BITS_RST   = 4'd0;
  localparam logic [BLK_CFG_W-1:0] BLOCK_BITS_RST = 5'd4;
  localparam logic [WAY_CFG_W-1:0] WAYS_USED_RST  = 4'd1;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_SPLIT,
    ST_ROW,
    ST_LOAD,
    ST_TAG,
    ST_CMP,
    ST_UPD,
    ST_FIN
  } state_t;

endpackage

/* hdl/salc_ram.sv */
// Generic simple dual-port RAM with one write port and one registered read port.
module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hdl/set_assoc_lru_cache_stats.sv */
// Top level of the set-associative write-back LRU cache simulator with saturating statistics.
//
//   channel | direction | handshake            | word
//   --------+-----------+----------------------+-----------------------------------------
//   in      | input     | in_valid / in_ready  | op, address
//   out     | output    | out_valid / out_ready| flags, running totals, dirty bytes
//   cfg     | input     | cfg_valid / cfg_ready| register index, write data
//
// An access steps from acceptance through split, row read and row load, then a tag read and
// a compare for each LRU position scanned: the scan stops at the first hit, else it covers
// all E ways in use, each tag read going through the registered read port of the tag memory.
// Then come update and result load. After reset a clearing pass writes every set row once
// while in_ready stays low; configuration writes are taken throughout. A waiting result holds
// the sequencer in its final step until out_ready is seen; in_ready rises in the cycle after
// the result has moved to the output register.
module set_assoc_lru_cache_stats #(
  parameter int MAX_SET_BITS = 10,
  parameter int MAX_WAYS     = 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Access channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_op,
  input  logic [salc_pkg::ADDR_W-1:0]          in_address,
  // Result channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_hit,
  output logic                                 out_evicted,
  output logic                                 out_evicted_dirty,
  output logic [salc_pkg::CNT_W-1:0]           out_hit_total,
  output logic [salc_pkg::CNT_W-1:0]           out_miss_total,
  output logic [salc_pkg::CNT_W-1:0]           out_eviction_total,
  output logic [salc_pkg::CNT_W-1:0]           out_dirty_evicted_bytes,
  output logic [salc_pkg::NOW_W-1:0]           out_dirty_bytes_now,
  // Configuration channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [salc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [salc_pkg::CFG_DATA_W-1:0]      cfg_data
);

  import salc_pkg::*;

  // Derived sizes.
  localparam int NUM_SETS = 2 ** MAX_SET_BITS;
  localparam int SET_AW   = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WAYC_W   = $clog2(MAX_WAYS + 1);
  localparam int LINES    = NUM_SETS * MAX_WAYS;
  localparam int DC_W     = $clog2(LINES + 1);
  localparam int ROW_W    = 2 * MAX_WAYS + MAX_WAYS * WAY_W;
  localparam int TAG_AW   = SET_AW + WAY_W;
  localparam int TAG_DEPTH = 2 ** TAG_AW;
  localparam int DB_W     = (DC_W + 16 > NOW_W) ? DC_W + 16 : NOW_W;

  // Sequencer and configuration.
  state_t state_r, state_nxt;
  logic [SET_CFG_W-1:0] set_bits_r;
  logic [BLK_CFG_W-1:0] block_bits_r;
  logic [WAY_CFG_W-1:0] ways_used_r;
  logic [SET_AW-1:0]    clr_r;

  // Access being worked on.
  logic                 op_r;
  logic [ADDR_W-1:0]    addr_r;
  logic [SET_AW-1:0]    set_r;
  logic [ADDR_W-1:0]    tag_r;
  logic [MAX_WAYS-1:0]  valid_r;
  logic [MAX_WAYS-1:0]  dirty_r;
  logic [WAY_W-1:0]     ord_r [MAX_WAYS];
  logic [WAY_W-1:0]     p_r;
  logic                 hit_r;
  logic [WAY_W-1:0]     hit_pos_r;
  logic                 have_free_r;
  logic [WAY_W-1:0]     free_pos_r;
  logic                 ev_r;
  logic                 ev_dirty_r;

  // Statistics.
  logic [CNT_W-1:0]     hit_cnt_r;
  logic [CNT_W-1:0]     miss_cnt_r;
  logic [CNT_W-1:0]     evict_cnt_r;
  logic [CNT_W-1:0]     dev_bytes_r;
  logic [DC_W-1:0]      dcount_r;

  // Output register.
  logic                 out_valid_r;
  logic                 out_hit_r;
  logic                 out_ev_r;
  logic                 out_ev_dirty_r;
  logic [CNT_W-1:0]     out_hit_tot_r;
  logic [CNT_W-1:0]     out_miss_tot_r;
  logic [CNT_W-1:0]     out_ev_tot_r;
  logic [CNT_W-1:0]     out_dev_r;
  logic [NOW_W-1:0]     out_now_r;

  // Memory ports.
  logic                 row_we;
  logic [SET_AW-1:0]    row_waddr;
  logic [ROW_W-1:0]     row_wdata;
  logic [ROW_W-1:0]     row_rdata;
  logic                 tag_we;
  logic [TAG_AW-1:0]    tag_waddr;
  logic [TAG_AW-1:0]    tag_raddr;
  logic [ADDR_W-1:0]    tag_rdata;

  // Effective configuration.
  logic [BLK_CFG_W-1:0] s_eff;
  logic [BLK_CFG_W-1:0] b_eff;
  logic [WAYC_W-1:0]    e_eff;
  logic [WAY_W-1:0]     last_pos;
  logic [5:0]           tag_sh;
  logic [ADDR_W-1:0]    addr_sh;
  logic [SET_AW-1:0]    set_mask;

  // Compare step.
  logic                 cmp_valid;
  logic                 cmp_hit;
  logic                 cmp_free;
  logic                 cmp_done;

  // Update step.
  logic [WAY_W-1:0]     sel_pos;
  logic [WAY_W-1:0]     sel_way;
  logic                 old_dirty;
  logic                 dirty_dec;
  logic                 dirty_inc;
  logic [MAX_WAYS-1:0]  valid_new;
  logic [MAX_WAYS-1:0]  dirty_new;
  logic [WAY_W-1:0]     ord_up  [MAX_WAYS];
  logic [WAY_W-1:0]     ord_new [MAX_WAYS];
  logic [ROW_W-1:0]     upd_row;
  logic [ROW_W-1:0]     ident_row;
  logic [CNT_W:0]       blk_bytes;
  logic [CNT_W:0]       dev_sum;
  logic [DB_W-1:0]      now_wide;
  logic [NOW_W-1:0]     now_val;
  logic                 fin_load;

  // Clamp the configuration to the supported ranges.
  always_comb begin
    if (32'(set_bits_r) > MAX_SET_BITS) begin
      s_eff = BLK_CFG_W'(MAX_SET_BITS);
    end else begin
      s_eff = BLK_CFG_W'(set_bits_r);
    end
    b_eff = (block_bits_r > BLOCK_BITS_MAX) ? BLOCK_BITS_MAX : block_bits_r;
    if (ways_used_r == '0) begin
      e_eff = WAYC_W'(1);
    end else if (32'(ways_used_r) > MAX_WAYS) begin
      e_eff = WAYC_W'(MAX_WAYS);
    end else begin
      e_eff = WAYC_W'(ways_used_r);
    end
    last_pos = WAY_W'(e_eff - WAYC_W'(1));
    tag_sh   = 6'(s_eff) + 6'(b_eff);
    addr_sh  = addr_r >> b_eff;
    set_mask = ~({SET_AW{1'b1}} << s_eff);
  end

  // One compare per LRU position against the tag memory output.
  assign cmp_valid = valid_r[ord_r[p_r]];
  assign cmp_hit   = cmp_valid && (tag_rdata == tag_r) && !hit_r;
  assign cmp_free  = !cmp_valid && !have_free_r;
  assign cmp_done  = cmp_hit || (p_r == last_pos);

  // Pick the line that this access touches and work out its new row.
  always_comb begin
    if (hit_r) begin
      sel_pos = hit_pos_r;
    end else if (have_free_r) begin
      sel_pos = free_pos_r;
    end else begin
      sel_pos = '0;
    end
    sel_way   = ord_r[sel_pos];
    old_dirty = dirty_r[sel_way];
    valid_new = valid_r;
    dirty_new = dirty_r;
    if (!hit_r) begin
      valid_new[sel_way] = 1'b1;
      dirty_new[sel_way] = 1'b0;
    end
    if (op_r == OP_STORE) begin
      dirty_new[sel_way] = 1'b1;
    end
    dirty_dec = !hit_r && old_dirty && (dcount_r != '0);
    dirty_inc = (op_r == OP_STORE) && !(hit_r && old_dirty);
  end

  // Move the touched position to most recent, shifting the younger ones down.
  always_comb begin
    for (int q = 0; q < MAX_WAYS - 1; q++) begin
      ord_up[q] = ord_r[q + 1];
    end
    ord_up[MAX_WAYS-1] = ord_r[MAX_WAYS-1];
    for (int q = 0; q < MAX_WAYS; q++) begin
      if (WAY_W'(q) < sel_pos || WAY_W'(q) > last_pos) begin
        ord_new[q] = ord_r[q];
      end else if (WAY_W'(q) == last_pos) begin
        ord_new[q] = sel_way;
      end else begin
        ord_new[q] = ord_up[q];
      end
    end
  end

  // Pack the updated row and the reset row.
  always_comb begin
    upd_row   = '0;
    ident_row = '0;
    upd_row[MAX_WAYS-1:0]          = valid_new;
    upd_row[2*MAX_WAYS-1:MAX_WAYS] = dirty_new;
    for (int q = 0; q < MAX_WAYS; q++) begin
      upd_row[2*MAX_WAYS + q*WAY_W +: WAY_W]   = ord_new[q];
      ident_row[2*MAX_WAYS + q*WAY_W +: WAY_W] = WAY_W'(q);
    end
  end

  // Saturating sum of evicted dirty bytes and the live dirty byte count.
  always_comb begin
    blk_bytes = (CNT_W+1)'(1) << b_eff;
    dev_sum   = {1'b0, dev_bytes_r} + blk_bytes;
    now_wide  = DB_W'(dcount_r) << b_eff;
    if (now_wide > DB_W'(NOW_MAX)) begin
      now_val = NOW_MAX;
    end else begin
      now_val = now_wide[NOW_W-1:0];
    end
  end

  assign fin_load = (state_r == ST_FIN) && (!out_valid_r || out_ready);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLR: begin
        if (clr_r == SET_AW'(NUM_SETS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_SPLIT;
        end
      end
      ST_SPLIT: state_nxt = ST_ROW;
      ST_ROW:   state_nxt = ST_LOAD;
      ST_LOAD:  state_nxt = ST_TAG;
      ST_TAG:   state_nxt = ST_CMP;
      ST_CMP: begin
        state_nxt = cmp_done ? ST_UPD : ST_TAG;
      end
      ST_UPD:   state_nxt = ST_FIN;
      ST_FIN: begin
        if (fin_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Memory port drive.
  assign row_we    = (state_r == ST_CLR) || (state_r == ST_UPD);
  assign row_waddr = (state_r == ST_CLR) ? clr_r : set_r;
  assign row_wdata = (state_r == ST_CLR) ? ident_row : upd_row;
  assign tag_we    = (state_r == ST_UPD) && !hit_r;
  assign tag_waddr = {set_r, sel_way};
  assign tag_raddr = {set_r, ord_r[p_r]};

  // Control state, configuration and statistics.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLR;
      clr_r        <= '0;
      set_bits_r   <= SET_BITS_RST;
      block_bits_r <= BLOCK_BITS_RST;
      ways_used_r  <= WAYS_USED_RST;
      hit_cnt_r    <= '0;
      miss_cnt_r   <= '0;
      evict_cnt_r  <= '0;
      dev_bytes_r  <= '0;
      dcount_r     <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLR) begin
        clr_r <= clr_r + SET_AW'(1);
      end
      if (cfg_valid) begin
        case (cfg_index)
          CFG_SET_BITS:   set_bits_r   <= cfg_data[SET_CFG_W-1:0];
          CFG_BLOCK_BITS: block_bits_r <= cfg_data[BLK_CFG_W-1:0];
          CFG_WAYS_USED:  ways_used_r  <= cfg_data[WAY_CFG_W-1:0];
          default: ;
        endcase
      end
      if (state_r == ST_UPD) begin
        if (hit_r) begin
          if (hit_cnt_r != CNT_MAX) begin
            hit_cnt_r <= hit_cnt_r + CNT_W'(1);
          end
        end else begin
          if (miss_cnt_r != CNT_MAX) begin
            miss_cnt_r <= miss_cnt_r + CNT_W'(1);
          end
          if (!have_free_r) begin
            if (evict_cnt_r != CNT_MAX) begin
              evict_cnt_r <= evict_cnt_r + CNT_W'(1);
            end
            if (old_dirty) begin
              dev_bytes_r <= (dev_sum > {1'b0, CNT_MAX}) ? CNT_MAX : dev_sum[CNT_W-1:0];
            end
          end
        end
        dcount_r <= dcount_r - DC_W'(dirty_dec) + DC_W'(dirty_inc);
      end
      if (fin_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Access payload and lookup progress.
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      op_r   <= in_op;
      addr_r <= in_address;
    end
    if (state_r == ST_SPLIT) begin
      set_r <= addr_sh[SET_AW-1:0] & set_mask;
      tag_r <= addr_r >> tag_sh;
    end
    if (state_r == ST_LOAD) begin
      valid_r     <= row_rdata[MAX_WAYS-1:0];
      dirty_r     <= row_rdata[2*MAX_WAYS-1:MAX_WAYS];
      for (int q = 0; q < MAX_WAYS; q++) begin
        ord_r[q] <= row_rdata[2*MAX_WAYS + q*WAY_W +: WAY_W];
      end
      p_r         <= '0;
      hit_r       <= 1'b0;
      have_free_r <= 1'b0;
    end
    if (state_r == ST_CMP) begin
      if (cmp_hit) begin
        hit_r     <= 1'b1;
        hit_pos_r <= p_r;
      end
      if (cmp_free) begin
        have_free_r <= 1'b1;
        free_pos_r  <= p_r;
      end
      if (!cmp_done) begin
        p_r <= p_r + WAY_W'(1);
      end
    end
    if (state_r == ST_UPD) begin
      ev_r       <= !hit_r && !have_free_r;
      ev_dirty_r <= !hit_r && !have_free_r && old_dirty;
    end
    if (fin_load) begin
      out_hit_r      <= hit_r;
      out_ev_r       <= ev_r;
      out_ev_dirty_r <= ev_dirty_r;
      out_hit_tot_r  <= hit_cnt_r;
      out_miss_tot_r <= miss_cnt_r;
      out_ev_tot_r   <= evict_cnt_r;
      out_dev_r      <= dev_bytes_r;
      out_now_r      <= now_val;
    end
  end

  // Per-set row: valid bits, dirty bits and LRU order.
  salc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_SETS)
  ) u_row_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (row_waddr),
    .wdata (row_wdata),
    .raddr (set_r),
    .rdata (row_rdata)
  );

  // Line tags, one entry per set and way.
  salc_ram #(
    .WIDTH (ADDR_W),
    .DEPTH (TAG_DEPTH)
  ) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (tag_waddr),
    .wdata (tag_r),
    .raddr (tag_raddr),
    .rdata (tag_rdata)
  );

  // Port drive.
  assign in_ready                = (state_r == ST_IDLE);
  assign cfg_ready               = 1'b1;
  assign out_valid               = out_valid_r;
  assign out_hit                 = out_hit_r;
  assign out_evicted             = out_ev_r;
  assign out_evicted_dirty       = out_ev_dirty_r;
  assign out_hit_total           = out_hit_tot_r;
  assign out_miss_total          = out_miss_tot_r;
  assign out_eviction_total      = out_ev_tot_r;
  assign out_dirty_evicted_bytes = out_dev_r;
  assign out_dirty_bytes_now     = out_now_r;

  // A hit never evicts, and a dirty eviction is always an eviction.
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_hit_r && out_ev_r))
    else $error("result shows both a hit and an eviction");

  a_dirty_needs_evict: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ev_dirty_r) |-> out_ev_r)
    else $error("dirty eviction flagged without an eviction");

  // The position scan never runs past the last way in use.
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CMP) |-> (p_r <= last_pos))
    else $error("LRU position scan went past the last way in use");

  // An accepted word keeps the input closed through the split and row read steps.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (!in_ready ##1 !in_ready))
    else $error("input reopened while an access is in progress");

  // The dirty line count can never exceed the number of stored lines.
  a_dcount_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(dcount_r) <= LINES)
    else $error("dirty line count exceeds the number of lines");

endmodule

/* sim/tb.sv */
// Testbench for the set-associative LRU cache statistics block: directed and random accesses.
`timescale 1ns / 100ps

module tb;
  import salc_pkg::*;

  localparam int SET_LIMIT = 10;
  localparam int WAY_LIMIT = 8;
  localparam int NUM_SETS = 1 << SET_LIMIT;
  localparam int RAND_PHASES = 10;
  localparam int PHASE_WORDS = 193;
  localparam int SETTLE_CYCLES = 2 * WAY_LIMIT + 10;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

  // One result word, in the order of the output ports.
  typedef struct packed {
    logic             hit;
    logic             evicted;
    logic             evicted_dirty;
    logic [CNT_W-1:0] hit_total;
    logic [CNT_W-1:0] miss_total;
    logic [CNT_W-1:0] eviction_total;
    logic [CNT_W-1:0] dirty_evicted_bytes;
    logic [NOW_W-1:0] dirty_bytes_now;
  } result_t;

  // One row of the directed table: a register write or an access.
  typedef struct packed {
    logic                  is_cfg;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    logic                  op;
    logic [ADDR_W-1:0]     address;
    logic                  typed;
    result_t               res;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_op = OP_LOAD;
  logic [ADDR_W-1:0] in_address = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_hit, out_evicted, out_evicted_dirty;
  logic [CNT_W-1:0] out_hit_total, out_miss_total, out_eviction_total;
  logic [CNT_W-1:0] out_dirty_evicted_bytes;
  logic [NOW_W-1:0] out_dirty_bytes_now;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_SET_BITS;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Shadow copy of the cache contents, LRU order and statistics.
  logic [ADDR_W-1:0] shadow_tag [NUM_SETS][WAY_LIMIT];
  bit                shadow_valid [NUM_SETS][WAY_LIMIT];
  bit                shadow_dirty [NUM_SETS][WAY_LIMIT];
  bit [2:0]          shadow_lru [NUM_SETS][WAY_LIMIT];
  logic [CNT_W-1:0]  hits_seen = '0;
  logic [CNT_W-1:0]  misses_seen = '0;
  logic [CNT_W-1:0]  evictions_seen = '0;
  logic [CNT_W-1:0]  dirty_bytes_out = '0;
  int                dirty_lines = 0;
  logic [SET_CFG_W-1:0] set_bits_q = SET_BITS_RST;
  logic [BLK_CFG_W-1:0] block_bits_q = BLOCK_BITS_RST;
  logic [WAY_CFG_W-1:0] ways_used_q = WAYS_USED_RST;

  result_t expected_q [$];
  plan_row_t plan [$];
  int mismatches = 0;

  // Address pools of the current random phase.
  logic [ADDR_W-1:0] tag_pool [12];
  logic [ADDR_W-1:0] set_pool [4];
  int tag_count = 1;
  int set_count = 1;

  set_assoc_lru_cache_stats #(
    .MAX_SET_BITS(SET_LIMIT),
    .MAX_WAYS(WAY_LIMIT)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_op(in_op),
    .in_address(in_address),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_hit(out_hit),
    .out_evicted(out_evicted),
    .out_evicted_dirty(out_evicted_dirty),
    .out_hit_total(out_hit_total),
    .out_miss_total(out_miss_total),
    .out_eviction_total(out_eviction_total),
    .out_dirty_evicted_bytes(out_dirty_evicted_bytes),
    .out_dirty_bytes_now(out_dirty_bytes_now),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // Register values as the block uses them, after clamping.
  function automatic int eff_set_bits();
    return (set_bits_q > SET_LIMIT) ? SET_LIMIT : int'(set_bits_q);
  endfunction

  function automatic int eff_block_bits();
    return (block_bits_q > BLOCK_BITS_MAX) ? int'(BLOCK_BITS_MAX) : int'(block_bits_q);
  endfunction

  function automatic int eff_ways();
    if (ways_used_q == 0) return 1;
    return (ways_used_q > WAY_LIMIT) ? WAY_LIMIT : int'(ways_used_q);
  endfunction

  function automatic logic [CNT_W-1:0] sat_count_add(input logic [CNT_W-1:0] a,
                                                     input logic [CNT_W-1:0] inc);
    if (a >= CNT_MAX || inc >= CNT_MAX - a) return CNT_MAX;
    return a + inc;
  endfunction

  // Look one access up in the shadow cache, update it and build the result word.
  task automatic cache_access(input logic op, input logic [ADDR_W-1:0] addr,
                              output result_t r);
    int s, b, e, last, p, q, hit_pos, free_pos, si;
    bit found, have_free;
    logic [ADDR_W-1:0] tag;
    logic [2:0] w;
    logic [CNT_W-1:0] block_bytes;
    s = eff_set_bits();
    b = eff_block_bits();
    e = eff_ways();
    last = e - 1;
    block_bytes = 48'd1 << b;
    si = int'((addr >> b) & ((64'd1 << s) - 64'd1));
    tag = addr >> (s + b);
    found = 1'b0;
    have_free = 1'b0;
    hit_pos = 0;
    free_pos = 0;
    r = '0;

    // Only the first ways_used LRU positions take part in the lookup.
    for (p = 0; p < e; p++) begin
      w = shadow_lru[si][p];
      if (shadow_valid[si][w]) begin
        if (!found && shadow_tag[si][w] == tag) begin
          found = 1'b1;
          hit_pos = p;
        end
      end else if (!have_free) begin
        have_free = 1'b1;
        free_pos = p;
      end
    end

    // A miss fills the first empty line, or else replaces the oldest one.
    if (found) begin
      hits_seen = sat_count_add(hits_seen, 48'd1);
      p = hit_pos;
    end else begin
      misses_seen = sat_count_add(misses_seen, 48'd1);
      p = have_free ? free_pos : 0;
      w = shadow_lru[si][p];
      if (!have_free) begin
        r.evicted = 1'b1;
        evictions_seen = sat_count_add(evictions_seen, 48'd1);
        if (shadow_dirty[si][w]) begin
          r.evicted_dirty = 1'b1;
          dirty_bytes_out = sat_count_add(dirty_bytes_out, block_bytes);
          if (dirty_lines > 0) dirty_lines--;
        end
      end else if (shadow_dirty[si][w]) begin
        if (dirty_lines > 0) dirty_lines--;
      end
      shadow_tag[si][w] = tag;
      shadow_valid[si][w] = 1'b1;
      shadow_dirty[si][w] = 1'b0;
    end

    // A store marks the line dirty; a hit keeps whatever dirty bit it had.
    w = shadow_lru[si][p];
    if (op == OP_STORE && !shadow_dirty[si][w]) begin
      shadow_dirty[si][w] = 1'b1;
      dirty_lines++;
    end
    for (q = p; q < last; q++) shadow_lru[si][q] = shadow_lru[si][q + 1];
    shadow_lru[si][last] = w;

    r.hit = found;
    r.hit_total = hits_seen;
    r.miss_total = misses_seen;
    r.eviction_total = evictions_seen;
    r.dirty_evicted_bytes = dirty_bytes_out;
    if (dirty_lines > (NOW_MAX >> b)) r.dirty_bytes_now = NOW_MAX;
    else r.dirty_bytes_now = NOW_W'(dirty_lines << b);
  endtask

  // Compare a result word with the oldest expectation, field by field.
  task automatic check_result(input result_t got);
    result_t want;
    if (expected_q.size() == 0) begin
      $error("result word arrived with no access pending");
      mismatches++;
      return;
    end
    want = expected_q.pop_front();
    if (got.hit !== want.hit) begin
      $error("hit: expected %0d, got %0d", want.hit, got.hit);
      mismatches++;
    end
    if (got.evicted !== want.evicted) begin
      $error("evicted: expected %0d, got %0d", want.evicted, got.evicted);
      mismatches++;
    end
    if (got.evicted_dirty !== want.evicted_dirty) begin
      $error("evicted_dirty: expected %0d, got %0d", want.evicted_dirty, got.evicted_dirty);
      mismatches++;
    end
    if (got.hit_total !== want.hit_total) begin
      $error("hit_total: expected %0d, got %0d", want.hit_total, got.hit_total);
      mismatches++;
    end
    if (got.miss_total !== want.miss_total) begin
      $error("miss_total: expected %0d, got %0d", want.miss_total, got.miss_total);
      mismatches++;
    end
    if (got.eviction_total !== want.eviction_total) begin
      $error("eviction_total: expected %0d, got %0d", want.eviction_total, got.eviction_total);
      mismatches++;
    end
    if (got.dirty_evicted_bytes !== want.dirty_evicted_bytes) begin
      $error("dirty_evicted_bytes: expected %0d, got %0d",
             want.dirty_evicted_bytes, got.dirty_evicted_bytes);
      mismatches++;
    end
    if (got.dirty_bytes_now !== want.dirty_bytes_now) begin
      $error("dirty_bytes_now: expected %0d, got %0d", want.dirty_bytes_now, got.dirty_bytes_now);
      mismatches++;
    end
  endtask

  // Result monitor: every word taken from the block is checked.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      check_result({out_hit, out_evicted, out_evicted_dirty, out_hit_total, out_miss_total,
                    out_eviction_total, out_dirty_evicted_bytes, out_dirty_bytes_now});
    end
  end

  // The result side stalls in regimes that take turns, chosen from a free-running cycle counter:
  // always ready, short random stalls, long stalls and a strict toggle.
  int stall_hold = 0;
  int rx_cycle = 0;
  always @(negedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      case (rx_cycle[10:9])
        2'd0: out_ready <= 1'b1;
        2'd1: begin
          out_ready <= ($urandom_range(0, 3) != 0);
          stall_hold <= $urandom_range(0, 3);
        end
        2'd2: begin
          if (out_ready) begin
            out_ready <= 1'b0;
            stall_hold <= $urandom_range(5, 30);
          end else begin
            out_ready <= 1'b1;
            stall_hold <= $urandom_range(0, 4);
          end
        end
        default: out_ready <= ~out_ready;
      endcase
    end
  end

  // Present one access word and hold it until the block takes it.
  task automatic put_access(input logic op, input logic [ADDR_W-1:0] addr,
                            output result_t pred);
    @(negedge clk);
    in_valid <= 1'b1;
    in_op <= op;
    in_address <= addr;
    do @(posedge clk); while (!in_ready);
    cache_access(op, addr, pred);
  endtask

  task automatic idle_sender(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  // Stop sending and wait until every expected word has been checked.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_SET_BITS:   set_bits_q = val[SET_CFG_W-1:0];
      CFG_BLOCK_BITS: block_bits_q = val;
      CFG_WAYS_USED:  ways_used_q = val[WAY_CFG_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic plan_row_t access_row(input logic op, input logic [ADDR_W-1:0] addr);
    plan_row_t row;
    row = '0;
    row.op = op;
    row.address = addr;
    return row;
  endfunction

  function automatic plan_row_t checked_row(input logic op, input logic [ADDR_W-1:0] addr,
                                            input result_t res);
    plan_row_t row;
    row = access_row(op, addr);
    row.typed = 1'b1;
    row.res = res;
    return row;
  endfunction

  function automatic plan_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] val);
    plan_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val;
    return row;
  endfunction

  // Pick a small working set of tags and sets so that hits and evictions both occur.
  task automatic refill_pools();
    int s, i;
    s = eff_set_bits();
    tag_count = $urandom_range(1, eff_ways() + 3);
    set_count = $urandom_range(1, 4);
    for (i = 0; i < tag_count; i++) tag_pool[i] = {$urandom, $urandom};
    for (i = 0; i < set_count; i++) set_pool[i] = {$urandom, $urandom} & ((64'd1 << s) - 64'd1);
  endtask

  // Mostly working-set addresses with a random offset; now and then a wild address.
  function automatic logic [ADDR_W-1:0] random_address();
    logic [ADDR_W-1:0] offset;
    int s, b;
    s = eff_set_bits();
    b = eff_block_bits();
    if ($urandom_range(0, 6) == 0) return {$urandom, $urandom};
    offset = {$urandom, $urandom} & ((64'd1 << b) - 64'd1);
    return (tag_pool[$urandom_range(0, tag_count - 1)] << (s + b))
         | (set_pool[$urandom_range(0, set_count - 1)] << b) | offset;
  endfunction

  // Run limit.
  initial begin
    #6_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    int si, wi, phase, left, burst, k, waited;
    logic [CFG_DATA_W-1:0] sb, bb, wu;
    result_t pred;

    for (si = 0; si < NUM_SETS; si++)
      for (wi = 0; wi < WAY_LIMIT; wi++) shadow_lru[si][wi] = wi[2:0];

    // Directed table. With the reset setting (one set, 16-byte blocks, one way)
    // the first words can be read off directly: miss, hit by a store, dirty eviction.
    plan.push_back(checked_row(OP_LOAD, 64'h0,
        {1'b0, 1'b0, 1'b0, 48'd0, 48'd1, 48'd0, 48'd0, 30'd0}));
    plan.push_back(checked_row(OP_STORE, 64'h8,
        {1'b1, 1'b0, 1'b0, 48'd1, 48'd1, 48'd0, 48'd0, 30'd16}));
    plan.push_back(checked_row(OP_LOAD, 64'hFFFF_FFFF_FFFF_FFFF,
        {1'b0, 1'b1, 1'b1, 48'd1, 48'd2, 48'd1, 48'd16, 30'd0}));
    plan.push_back(checked_row(OP_STORE, 64'hFFFF_FFFF_FFFF_FFF0,
        {1'b1, 1'b0, 1'b0, 48'd2, 48'd2, 48'd1, 48'd16, 30'd16}));
    plan.push_back(checked_row(OP_LOAD, 64'h10,
        {1'b0, 1'b1, 1'b1, 48'd2, 48'd3, 48'd2, 48'd32, 30'd0}));
    // A hit on a dirty line keeps it dirty.
    plan.push_back(access_row(OP_STORE, 64'h10));
    plan.push_back(access_row(OP_LOAD, 64'h18));
    plan.push_back(access_row(OP_STORE, 64'h20));
    // Using more ways keeps the stored lines.
    plan.push_back(reg_row(CFG_WAYS_USED, 5'd8));
    plan.push_back(access_row(OP_LOAD, 64'h10));
    // Oversized set and block counts clamp; zero ways acts as one.
    plan.push_back(reg_row(CFG_SET_BITS, 5'd31));
    plan.push_back(reg_row(CFG_BLOCK_BITS, 5'd31));
    plan.push_back(reg_row(CFG_WAYS_USED, 5'd0));
    plan.push_back(access_row(OP_STORE, 64'hFFFF_FFFF_FFFF_FFFF));
    plan.push_back(access_row(OP_STORE, 64'h0));
    plan.push_back(access_row(OP_LOAD, 64'h8000_0000_0000_0000));
    // Byte blocks, one set, oversized ways: nine stores overflow eight ways.
    plan.push_back(reg_row(CFG_SET_BITS, 5'd0));
    plan.push_back(reg_row(CFG_BLOCK_BITS, 5'd0));
    plan.push_back(reg_row(CFG_WAYS_USED, 5'd15));
    for (k = 0; k < 9; k++) plan.push_back(access_row(OP_STORE, ADDR_W'(k)));
    plan.push_back(access_row(OP_LOAD, 64'h1));
    // A write to the unused index changes nothing.
    plan.push_back(reg_row(CFG_UNMAPPED, 5'd31));
    plan.push_back(reg_row(CFG_SET_BITS, 5'd10));
    plan.push_back(reg_row(CFG_BLOCK_BITS, 5'd16));
    plan.push_back(reg_row(CFG_WAYS_USED, 5'd8));
    plan.push_back(access_row(OP_STORE, 64'hFFFF_FFFF_FFFF_FFFF));
    plan.push_back(access_row(OP_LOAD, 64'h5555_5555_5555_5555));
    plan.push_back(access_row(OP_STORE, 64'hAAAA_AAAA_AAAA_AAAA));

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        drain_results();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        put_access(plan[i].op, plan[i].address, pred);
        expected_q.push_back(plan[i].typed ? plan[i].res : pred);
        idle_sender($urandom_range(0, 2));
      end
    end

    // Random phases, each under its own setting; the first two are the extremes.
    for (phase = 0; phase < RAND_PHASES; phase++) begin
      drain_results();
      case (phase)
        0: begin
          sb = 5'd0;
          bb = 5'd0;
          wu = 5'd1;
        end
        1: begin
          sb = 5'd10;
          bb = 5'd16;
          wu = 5'd8;
        end
        default: begin
          sb = CFG_DATA_W'($urandom_range(0, 31));
          bb = CFG_DATA_W'($urandom_range(0, 31));
          wu = CFG_DATA_W'($urandom_range(0, 31));
        end
      endcase
      write_reg(CFG_SET_BITS, sb);
      write_reg(CFG_BLOCK_BITS, bb);
      write_reg(CFG_WAYS_USED, wu);
      refill_pools();

      // Bursts of words; every third phase sends without gaps.
      left = PHASE_WORDS;
      while (left > 0) begin
        burst = $urandom_range(1, 24);
        for (k = 0; k < burst && left > 0; k++) begin
          put_access(1'($urandom_range(0, 1)), random_address(), pred);
          expected_q.push_back(pred);
          left--;
        end
        if ($urandom_range(0, 30) == 0) drain_results();
        else if (phase % 3 != 2) idle_sender($urandom_range(1, 6));
      end
    end

    // Let the last results come out, then watch for stray words.
    @(negedge clk);
    in_valid <= 1'b0;
    waited = 0;
    while (expected_q.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    if (expected_q.size() != 0) begin
      $error("%0d expected results never arrived", expected_q.size());
      mismatches++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
